/* hdl/cld_pkg.sv */
package cld_pkg;

  // field and register widths
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // register index codes (byte address / 4)
  localparam logic [2:0] REG_LOCK_TICKS        = 3'd0;
  localparam logic [2:0] REG_FREE_TICKS        = 3'd1;
  localparam logic [2:0] REG_ANCHOR_LOSS_TICKS = 3'd2;
  localparam logic [2:0] REG_WARP_QUIET_TICKS  = 3'd3;
  localparam logic [2:0] REG_BOX_WINDOW_TICKS  = 3'd4;
  localparam logic [2:0] REG_RAW_ACTIVE_FLOOR  = 3'd5;

  // register reset values (144 Hz figures)
  localparam logic [CFG_W-1:0] LOCK_TICKS_RST        = 10'd6;
  localparam logic [CFG_W-1:0] FREE_TICKS_RST        = 10'd3;
  localparam logic [CFG_W-1:0] ANCHOR_LOSS_TICKS_RST = 10'd45;
  localparam logic [CFG_W-1:0] WARP_QUIET_TICKS_RST  = 10'd12;
  localparam logic [CFG_W-1:0] BOX_WINDOW_TICKS_RST  = 10'd24;
  localparam logic [CFG_W-1:0] RAW_ACTIVE_FLOOR_RST  = 10'd4;

  // detector constants
  localparam logic signed [16:0] ANCHOR_TOL   = 17'sd6;
  localparam logic [15:0]        WARP_JUMP    = 16'd100;
  localparam logic [7:0]         LOCK_RETURNS = 8'd4;
  localparam logic [31:0]        BOX_RAW_SUM  = 32'd400;
  localparam logic signed [16:0] BOX_SPAN     = 17'sd30;
  localparam logic [9:0]         SINCE_CAP    = 10'd1000;
  localparam logic [9:0]         BOX_CNT_MAX  = 10'd1023;

  typedef struct packed {
    logic [CFG_W-1:0] lock_ticks;
    logic [CFG_W-1:0] free_ticks;
    logic [CFG_W-1:0] anchor_loss_ticks;
    logic [CFG_W-1:0] warp_quiet_ticks;
    logic [CFG_W-1:0] box_window_ticks;
    logic [CFG_W-1:0] raw_active_floor;
  } cfg_t;

  typedef struct packed {
    logic               clip_confined;
    logic [15:0]        raw_motion;
    logic [15:0]        cursor_motion;
    logic               warp_tell;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } item_t;

  typedef struct packed {
    logic               lock_flag;
    logic [15:0]        lock_streak;
    logic [15:0]        free_streak;
    logic               anchor_valid;
    logic signed [15:0] anchor_px;
    logic signed [15:0] anchor_py;
    logic [15:0]        anchor_misses;
    logic [7:0]         warp_returns;
    logic [9:0]         ticks_since_warp;
    logic [9:0]         box_count;
    logic [31:0]        box_motion_sum;
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_min_y;
    logic signed [15:0] box_max_y;
  } state_t;

endpackage

/* hdl/cld_cfg.sv */
module cld_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cld_pkg::PADDR_W-1:0]   paddr,
  input  logic [cld_pkg::PDATA_W-1:0]   pwdata,
  output logic [cld_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output cld_pkg::cfg_t                 cfg
);
  import cld_pkg::*;

  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lock_ticks        <= LOCK_TICKS_RST;
      cfg.free_ticks        <= FREE_TICKS_RST;
      cfg.anchor_loss_ticks <= ANCHOR_LOSS_TICKS_RST;
      cfg.warp_quiet_ticks  <= WARP_QUIET_TICKS_RST;
      cfg.box_window_ticks  <= BOX_WINDOW_TICKS_RST;
      cfg.raw_active_floor  <= RAW_ACTIVE_FLOOR_RST;
    end else if (wr_en) begin
      case (idx)
        REG_LOCK_TICKS:        cfg.lock_ticks        <= pwdata[CFG_W-1:0];
        REG_FREE_TICKS:        cfg.free_ticks        <= pwdata[CFG_W-1:0];
        REG_ANCHOR_LOSS_TICKS: cfg.anchor_loss_ticks <= pwdata[CFG_W-1:0];
        REG_WARP_QUIET_TICKS:  cfg.warp_quiet_ticks  <= pwdata[CFG_W-1:0];
        REG_BOX_WINDOW_TICKS:  cfg.box_window_ticks  <= pwdata[CFG_W-1:0];
        REG_RAW_ACTIVE_FLOOR:  cfg.raw_active_floor  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LOCK_TICKS:        prdata = PDATA_W'(cfg.lock_ticks);
      REG_FREE_TICKS:        prdata = PDATA_W'(cfg.free_ticks);
      REG_ANCHOR_LOSS_TICKS: prdata = PDATA_W'(cfg.anchor_loss_ticks);
      REG_WARP_QUIET_TICKS:  prdata = PDATA_W'(cfg.warp_quiet_ticks);
      REG_BOX_WINDOW_TICKS:  prdata = PDATA_W'(cfg.box_window_ticks);
      REG_RAW_ACTIVE_FLOOR:  prdata = PDATA_W'(cfg.raw_active_floor);
      default:               prdata = '0;
    endcase
  end

endmodule

/* hdl/cld_step.sv */
module cld_step (
  input  cld_pkg::cfg_t   cfg,
  input  cld_pkg::item_t  item,
  input  cld_pkg::state_t cur,
  output cld_pkg::state_t nxt
);
  import cld_pkg::*;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  logic               landing;
  logic               near;
  logic               jump;
  logic               box_hit;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [16:0] span_x;
  logic signed [16:0] span_y;
  logic signed [15:0] bmin_x;
  logic signed [15:0] bmax_x;
  logic signed [15:0] bmin_y;
  logic signed [15:0] bmax_y;
  logic [31:0]        sum_base;
  logic [32:0]        sum_wide;
  logic [9:0]         count_inc;

  assign dx   = 17'(item.pos_x) - 17'(cur.anchor_px);
  assign dy   = 17'(item.pos_y) - 17'(cur.anchor_py);
  assign jump = item.cursor_motion >= WARP_JUMP;

  always_comb begin
    nxt      = cur;
    landing  = 1'b0;
    near     = 1'b0;
    box_hit  = 1'b0;
    bmin_x   = cur.box_min_x;
    bmax_x   = cur.box_max_x;
    bmin_y   = cur.box_min_y;
    bmax_y   = cur.box_max_y;
    sum_base = cur.box_motion_sum;
    sum_wide = '0;
    count_inc = cur.box_count;
    span_x   = '0;
    span_y   = '0;

    if (item.clip_confined) begin
      // clip rectangle forces the lock and clears both streaks, nothing else moves
      nxt.lock_flag   = 1'b1;
      nxt.lock_streak = '0;
      nxt.free_streak = '0;
    end else begin
      if (cur.ticks_since_warp < SINCE_CAP) begin
        nxt.ticks_since_warp = cur.ticks_since_warp + 10'd1;
      end

      if (item.warp_tell) begin
        // warp anchor
        near = cur.anchor_valid && (dx >= -ANCHOR_TOL) && (dx <= ANCHOR_TOL) &&
               (dy >= -ANCHOR_TOL) && (dy <= ANCHOR_TOL);
        if (near) begin
          nxt.anchor_misses = '0;
          if (jump) begin
            landing              = 1'b1;
            nxt.ticks_since_warp = '0;
            if (cur.warp_returns != 8'hFF) begin
              nxt.warp_returns = cur.warp_returns + 8'd1;
            end
            if (nxt.warp_returns >= LOCK_RETURNS) begin
              nxt.lock_flag = 1'b1;
            end
          end
        end else if (cur.anchor_valid) begin
          nxt.anchor_misses = sat_inc16(cur.anchor_misses);
          if (nxt.anchor_misses > 16'(cfg.anchor_loss_ticks)) begin
            nxt.anchor_valid = 1'b0;
            nxt.warp_returns = '0;
          end
        end
        if (!nxt.anchor_valid && jump) begin
          nxt.anchor_px     = item.pos_x;
          nxt.anchor_py     = item.pos_y;
          nxt.anchor_valid  = 1'b1;
          nxt.anchor_misses = '0;
          nxt.warp_returns  = '0;
        end

        // tumbling box, restarted at window start
        if (cur.box_count == '0) begin
          bmin_x   = item.pos_x;
          bmax_x   = item.pos_x;
          bmin_y   = item.pos_y;
          bmax_y   = item.pos_y;
          sum_base = '0;
        end
        nxt.box_min_x = (item.pos_x < bmin_x) ? item.pos_x : bmin_x;
        nxt.box_max_x = (item.pos_x > bmax_x) ? item.pos_x : bmax_x;
        nxt.box_min_y = (item.pos_y < bmin_y) ? item.pos_y : bmin_y;
        nxt.box_max_y = (item.pos_y > bmax_y) ? item.pos_y : bmax_y;
        sum_wide = {1'b0, sum_base} + 33'(item.raw_motion);
        nxt.box_motion_sum = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
        if (cur.box_count != BOX_CNT_MAX) begin
          count_inc = cur.box_count + 10'd1;
        end
        nxt.box_count = count_inc;
        span_x = 17'(nxt.box_max_x) - 17'(nxt.box_min_x);
        span_y = 17'(nxt.box_max_y) - 17'(nxt.box_min_y);
        if (count_inc >= cfg.box_window_ticks) begin
          box_hit = (nxt.box_motion_sum >= BOX_RAW_SUM) &&
                    (span_x <= BOX_SPAN) && (span_y <= BOX_SPAN);
          if (box_hit) begin
            nxt.lock_flag = 1'b1;
            if (nxt.warp_returns == '0) begin
              nxt.warp_returns = 8'd1;
            end
            nxt.ticks_since_warp = '0;
            nxt.free_streak      = '0;
            nxt.lock_streak      = '0;
          end
          nxt.box_count = '0;
        end
      end

      // lock and free streaks
      if (landing) begin
        nxt.free_streak = '0;
        nxt.lock_streak = '0;
      end else if (item.cursor_motion != '0) begin
        nxt.free_streak = sat_inc16(nxt.free_streak);
        nxt.lock_streak = '0;
        if ((nxt.free_streak >= 16'(cfg.free_ticks)) &&
            (nxt.ticks_since_warp > cfg.warp_quiet_ticks)) begin
          nxt.lock_flag    = 1'b0;
          nxt.warp_returns = '0;
        end
      end else if (item.raw_motion >= 16'(cfg.raw_active_floor)) begin
        nxt.lock_streak = sat_inc16(nxt.lock_streak);
        nxt.free_streak = '0;
        if (nxt.lock_streak >= 16'(cfg.lock_ticks)) begin
          nxt.lock_flag = 1'b1;
        end
      end else begin
        nxt.lock_streak = '0;
        nxt.free_streak = '0;
      end
    end
  end

endmodule

/* hdl/cursor_lock_detector.sv */
// pointer lock detector: takes one pointer tick per item and returns one item
// carrying the locked flag. a confining clip rectangle locks at once; otherwise
// lock comes from repeated warps back onto an anchor, from a busy mouse whose
// cursor stays inside a small tumbling box, or from a streak of frozen-cursor
// ticks with raw motion, and is released by a streak of cursor movement with
// no recent warp landing. one item is taken every clock cycle while the result
// register is free or being emptied; a result is offered once its item has
// passed the input register and the state update has been written into the
// result register. the six thresholds, five tick counts and a raw motion floor,
// sit in an apb register file at byte addresses 0x00 to 0x14 and reset to
// 144 Hz values; change them only while no item is in flight
module cursor_lock_detector (
  input  logic                        clk,
  input  logic                        rst,
  // apb configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cld_pkg::PADDR_W-1:0] paddr,
  input  logic [cld_pkg::PDATA_W-1:0] pwdata,
  output logic [cld_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // tick items in
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic                        clip_confined,
  input  logic [15:0]                 raw_motion,
  input  logic [15:0]                 cursor_motion,
  input  logic                        warp_tell,
  input  logic signed [15:0]          pos_x,
  input  logic signed [15:0]          pos_y,
  // result items out
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        locked
);
  import cld_pkg::*;

  cfg_t   cfg;
  item_t  in_item;
  logic   in_full;
  state_t state;
  state_t state_next;
  logic   advance;

  cld_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the held item moves on when the result register is free or being emptied
  assign advance    = in_full && (!result_valid || result_ready);
  assign item_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_item.clip_confined <= clip_confined;
      in_item.raw_motion    <= raw_motion;
      in_item.cursor_motion <= cursor_motion;
      in_item.warp_tell     <= warp_tell;
      in_item.pos_x         <= pos_x;
      in_item.pos_y         <= pos_y;
    end
  end

  // whole tick update in one pass
  cld_step u_step (
    .cfg  (cfg),
    .item (in_item),
    .cur  (state),
    .nxt  (state_next)
  );

  // tracker state; anchor position and box bounds are written before any read
  always_ff @(posedge clk) begin
    if (rst) begin
      state.lock_flag        <= 1'b0;
      state.lock_streak      <= '0;
      state.free_streak      <= '0;
      state.anchor_valid     <= 1'b0;
      state.anchor_misses    <= '0;
      state.warp_returns     <= '0;
      state.ticks_since_warp <= SINCE_CAP;
      state.box_count        <= '0;
      state.box_motion_sum   <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register, parts the two handshakes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      locked <= state_next.lock_flag;
    end
  end

  // warp age counter never runs past its cap
  a_since_cap : assert property (@(posedge clk) disable iff (rst)
    state.ticks_since_warp <= SINCE_CAP)
    else $error("ticks since warp above cap");

  // a confined tick always reports locked
  a_clip_locks : assert property (@(posedge clk) disable iff (rst)
    (advance && in_item.clip_confined) |=> (result_valid && locked))
    else $error("clip confined tick not locked");

  // a stalled item stays in the input register untouched
  a_in_hold : assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> (in_full && $stable(in_item)))
    else $error("held item lost or changed");

  // every update produces a result
  a_result : assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("update without result");

endmodule
